// ===== rtl/wdhp_pkg.sv =====
`timescale 1ns / 1ps

package wdhp_pkg;

	// Interface count limits and defaults.
	localparam int unsigned NumIfacesMax = 16;
	localparam int unsigned NumIfacesDef = 16;

	localparam int unsigned IfaceW    = 4;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned DebounceW = 20;
	localparam int unsigned MaskW     = 16;
	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned CfgDataW  = 20;

	localparam logic [DebounceW-1:0] DebounceRst = DebounceW'(30000);

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgDebounce   = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDetectPol  = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgWakePol    = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgModulePort = 2'd3;

	// Per-pin debounce state codes. Codes above StInactStable act as invalid.
	localparam logic [2:0] StInvalid     = 3'd0;
	localparam logic [2:0] StActDb       = 3'd1;
	localparam logic [2:0] StInactDb     = 3'd2;
	localparam logic [2:0] StActStable   = 3'd3;
	localparam logic [2:0] StInactStable = 3'd4;

	// Power actions.
	localparam logic [1:0] PwrNone  = 2'd0;
	localparam logic [1:0] PwrOn    = 2'd1;
	localparam logic [1:0] PwrCycle = 2'd2;
	localparam logic [1:0] PwrOff   = 2'd3;

	// Hotplug events.
	localparam logic [1:0] HpNone    = 2'd0;
	localparam logic [1:0] HpPlug    = 2'd1;
	localparam logic [1:0] HpUnplug  = 2'd2;

	// One table entry per pin.
	typedef struct packed {
		logic [2:0]       dstate;
		logic [2:0]       lstate;
		logic [TimeW-1:0] ctime;
	} pin_entry_t;

	// Decision for one word, handed from the step logic to the top level.
	typedef struct packed {
		logic [1:0] power;
		logic [1:0] hotplug;
		logic       recheck;
	} pin_result_t;

endpackage

// ===== rtl/wdhp_state_mem.sv =====
`timescale 1ns / 1ps

// Per-pin state table: one synchronous read port, one write port, a valid bit per
// entry so that an entry never written reads as the reset value, and a bypass of the
// most recent write so a read issued on the same edge as a write sees the new data.
module wdhp_state_mem #(
	parameter int unsigned DEPTH = 2 * wdhp_pkg::NumIfacesDef,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output wdhp_pkg::pin_entry_t rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  wdhp_pkg::pin_entry_t wr_data
);

	wdhp_pkg::pin_entry_t mem [DEPTH];
	wdhp_pkg::pin_entry_t rd_raw_q;
	logic [AW-1:0]        rd_addr_q;
	logic [DEPTH-1:0]     valid_q;
	wdhp_pkg::pin_entry_t fwd_data_q;
	logic [AW-1:0]        fwd_addr_q;
	logic                 fwd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_valid_q <= 1'b0;
			rd_addr_q   <= '0;
			fwd_addr_q  <= '0;
		end else begin
			if (rd_en) begin
				rd_addr_q <= rd_addr;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
				fwd_valid_q      <= 1'b1;
				fwd_addr_q       <= wr_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_data_q <= wr_data;
		end
	end

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == rd_addr_q)) begin
			rd_data = fwd_data_q;
		end else if (valid_q[rd_addr_q]) begin
			rd_data = rd_raw_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ===== rtl/wdhp_step.sv =====
`timescale 1ns / 1ps

// Next-state and decision logic for one pin event.
module wdhp_step (
	input  wdhp_pkg::pin_entry_t              cur,
	input  logic                              active,
	input  logic                              drives,
	input  logic [wdhp_pkg::TimeW-1:0]        now_us,
	input  logic [wdhp_pkg::DebounceW-1:0]    debounce_us,
	output wdhp_pkg::pin_entry_t              nxt,
	output wdhp_pkg::pin_result_t             res
);

	logic [wdhp_pkg::TimeW-1:0] elapsed;
	logic                       settled;
	logic [2:0]                 db_code;

	assign elapsed = now_us - cur.ctime;
	assign settled = elapsed >= {{(wdhp_pkg::TimeW - wdhp_pkg::DebounceW){1'b0}}, debounce_us};
	assign db_code = active ? wdhp_pkg::StActDb : wdhp_pkg::StInactDb;

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.dstate)
			wdhp_pkg::StActDb, wdhp_pkg::StInactDb: begin
				if (active == (cur.dstate == wdhp_pkg::StActDb)) begin
					if (settled) begin
						if (active) begin
							nxt.dstate = wdhp_pkg::StActStable;
							nxt.lstate = wdhp_pkg::StActStable;
							if (drives) begin
								res.power   = (cur.lstate == wdhp_pkg::StActStable) ?
									wdhp_pkg::PwrCycle : wdhp_pkg::PwrOn;
								res.hotplug = wdhp_pkg::HpPlug;
							end
						end else begin
							nxt.dstate = wdhp_pkg::StInactStable;
							nxt.lstate = wdhp_pkg::StInactStable;
							if (drives) begin
								res.power   = wdhp_pkg::PwrOff;
								res.hotplug = wdhp_pkg::HpUnplug;
							end
						end
					end else begin
						res.recheck = 1'b1;
					end
				end else begin
					nxt.ctime   = now_us;
					nxt.dstate  = db_code;
					res.recheck = 1'b1;
				end
			end
			wdhp_pkg::StActStable, wdhp_pkg::StInactStable: begin
				if (active != (cur.dstate == wdhp_pkg::StActStable)) begin
					nxt.ctime   = now_us;
					nxt.dstate  = db_code;
					res.recheck = 1'b1;
				end
			end
			default: begin
				// Invalid or an unused code: start debouncing from this sample.
				nxt.ctime   = now_us;
				nxt.dstate  = db_code;
				res.recheck = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/wake_detect_debounce_hotplug_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_axis    in         tdata: iface_index, pin_level, now_us; tuser: pin_select
// m_axis    out        tdata: out_iface, power_action, hotplug_event, recheck_request
// cfg       in         cfg_we, cfg_index, cfg_wdata; registers 0..3, write only
//
// One word is accepted per cycle unless a stalled output holds the stage in flight.
// The acceptance edge reads the pin's entry from the state table; the edge on which
// that stage advances writes the updated entry back and loads the output register.
// A write to the entry read on the same edge is bypassed inside the table, so
// back-to-back words on one pin work. Reset marks every table entry invalid at once
// through per-entry valid bits; no clearing pass is needed. When the output register
// is full and not taken, the stage in flight holds and input stops only if that stage
// is also occupied.
module wake_detect_debounce_hotplug_unit #(
	parameter int unsigned NUM_IFACES = wdhp_pkg::NumIfacesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [3:0] iface_index, [4] pin_level, [36:5] now_us, rest 0
	input  logic        s_tuser,  // [0] pin_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [3:0] out_iface, [5:4] power_action,
	                              // [7:6] hotplug_event, [8] recheck_request, rest 0
	input  logic        cfg_we,
	input  logic [wdhp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [wdhp_pkg::CfgDataW-1:0] cfg_wdata
);

	localparam int unsigned Depth = 2 * NUM_IFACES;
	localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

	// Configuration registers.
	logic [wdhp_pkg::DebounceW-1:0] debounce_q;
	logic [wdhp_pkg::MaskW-1:0]     detect_pol_q;
	logic [wdhp_pkg::MaskW-1:0]     wake_pol_q;
	logic [wdhp_pkg::MaskW-1:0]     module_port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= wdhp_pkg::DebounceRst;
			detect_pol_q  <= '0;
			wake_pol_q    <= '0;
			module_port_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wdhp_pkg::CfgDebounce:   debounce_q    <= cfg_wdata;
				wdhp_pkg::CfgDetectPol:  detect_pol_q  <= cfg_wdata[wdhp_pkg::MaskW-1:0];
				wdhp_pkg::CfgWakePol:    wake_pol_q    <= cfg_wdata[wdhp_pkg::MaskW-1:0];
				wdhp_pkg::CfgModulePort: module_port_q <= cfg_wdata[wdhp_pkg::MaskW-1:0];
				default: ;
			endcase
		end
	end

	// Input unpacking.
	logic [wdhp_pkg::IfaceW-1:0] in_iface;
	logic                        in_level;
	logic [wdhp_pkg::TimeW-1:0]  in_now;
	logic [wdhp_pkg::IfaceW:0]   in_entry_full;
	logic [AW-1:0]               in_addr;

	assign in_iface      = s_tdata[3:0];
	assign in_level      = s_tdata[4];
	assign in_now        = s_tdata[36:5];
	assign in_entry_full = {in_iface, s_tuser};
	assign in_addr       = in_entry_full[AW-1:0];

	// Stage 1: table read data is valid here.
	logic                        s1_valid_q;
	logic [wdhp_pkg::IfaceW-1:0] iface_s1;
	logic                        pin_s1;
	logic                        level_s1;
	logic [wdhp_pkg::TimeW-1:0]  now_s1;
	logic [AW-1:0]               addr_s1;
	logic                        s1_adv;
	logic                        accept;

	// Output register.
	logic                        out_valid_q;
	logic [wdhp_pkg::IfaceW-1:0] out_iface_q;
	wdhp_pkg::pin_result_t       out_res_q;

	assign s1_adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			iface_s1 <= in_iface;
			pin_s1   <= s_tuser;
			level_s1 <= in_level;
			now_s1   <= in_now;
			addr_s1  <= in_addr;
		end
	end

	// Per-pin attributes from the configuration.
	logic in_range;
	logic pol;
	logic active;
	logic drives;

	assign in_range = {1'b0, iface_s1} < (wdhp_pkg::IfaceW + 1)'(NUM_IFACES);
	assign pol      = pin_s1 ? detect_pol_q[iface_s1] : wake_pol_q[iface_s1];
	assign active   = (level_s1 == pol);
	assign drives   = pin_s1 || module_port_q[iface_s1];

	wdhp_pkg::pin_entry_t  cur_entry;
	wdhp_pkg::pin_entry_t  nxt_entry;
	wdhp_pkg::pin_result_t step_res;
	logic                  wr_en;

	assign wr_en = s1_adv && in_range;

	wdhp_state_mem #(
		.DEPTH (Depth),
		.AW    (AW)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (cur_entry),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt_entry)
	);

	wdhp_step u_step (
		.cur         (cur_entry),
		.active      (active),
		.drives      (drives),
		.now_us      (now_s1),
		.debounce_us (debounce_q),
		.nxt         (nxt_entry),
		.res         (step_res)
	);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_iface_q <= iface_s1;
			out_res_q   <= in_range ? step_res : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_res_q.recheck, out_res_q.hotplug, out_res_q.power, out_iface_q};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Decision expected for one pin word, in the order of the output fields.
typedef struct packed {
	logic [3:0] iface;
	logic [1:0] power;
	logic [1:0] hotplug;
	logic       recheck;
} hotplug_outcome_t;

// Keeps its own copy of the per-pin debounce table and the registers, works out the
// decision for every accepted pin word and compares result words against them in order.
class hotplug_scoreboard;
	logic [19:0] debounce_limit;
	logic [15:0] detect_pol;
	logic [15:0] wake_pol;
	logic [15:0] module_ports;
	logic [2:0]  pin_phase [32];
	logic [2:0]  settled_phase [32];
	logic [31:0] since_us [32];
	hotplug_outcome_t expected_outcomes [$];
	int failures;

	function new();
		debounce_limit = wdhp_pkg::DebounceRst;
		detect_pol = '0;
		wake_pol = '0;
		module_ports = '0;
		for (int i = 0; i < 32; i++) begin
			pin_phase[i] = wdhp_pkg::StInvalid;
			settled_phase[i] = wdhp_pkg::StInvalid;
			since_us[i] = '0;
		end
		failures = 0;
	endfunction

	function void set_register(logic [wdhp_pkg::CfgIdxW-1:0] idx,
			logic [wdhp_pkg::CfgDataW-1:0] value);
		case (idx)
			wdhp_pkg::CfgDebounce:   debounce_limit = value;
			wdhp_pkg::CfgDetectPol:  detect_pol = value[15:0];
			wdhp_pkg::CfgWakePol:    wake_pol = value[15:0];
			wdhp_pkg::CfgModulePort: module_ports = value[15:0];
			default: ;
		endcase
	endfunction

	// A level that differs from the tracked one starts a fresh debounce window.
	function void start_debounce(int e, bit active, logic [31:0] stamp);
		since_us[e] = stamp;
		pin_phase[e] = active ? wdhp_pkg::StActDb : wdhp_pkg::StInactDb;
	endfunction

	function hotplug_outcome_t predict_outcome(logic [3:0] ifc, logic pin, logic level,
			logic [31:0] stamp);
		hotplug_outcome_t o;
		int e;
		bit active;
		bit drives;
		logic [2:0] st;
		logic [31:0] elapsed;
		o = '0;
		o.iface = ifc;
		if (ifc >= wdhp_pkg::NumIfacesDef)
			return o;
		e = ifc * 2 + pin;
		active = (level == (pin ? detect_pol[ifc] : wake_pol[ifc]));
		drives = pin || module_ports[ifc];
		st = pin_phase[e];
		case (st)
			wdhp_pkg::StActDb, wdhp_pkg::StInactDb: begin
				if ((st == wdhp_pkg::StActDb) != active) begin
					start_debounce(e, active, stamp);
					o.recheck = 1'b1;
				end else begin
					// Time differences wrap modulo 2^32.
					elapsed = stamp - since_us[e];
					if (elapsed >= 32'(debounce_limit)) begin
						if (active) begin
							pin_phase[e] = wdhp_pkg::StActStable;
							if (drives) begin
								o.power = (settled_phase[e] == wdhp_pkg::StActStable) ?
									wdhp_pkg::PwrCycle : wdhp_pkg::PwrOn;
								o.hotplug = wdhp_pkg::HpPlug;
							end
						end else begin
							pin_phase[e] = wdhp_pkg::StInactStable;
							if (drives) begin
								o.power = wdhp_pkg::PwrOff;
								o.hotplug = wdhp_pkg::HpUnplug;
							end
						end
						settled_phase[e] = pin_phase[e];
					end else begin
						o.recheck = 1'b1;
					end
				end
			end
			wdhp_pkg::StActStable, wdhp_pkg::StInactStable: begin
				if ((st == wdhp_pkg::StActStable) != active) begin
					start_debounce(e, active, stamp);
					o.recheck = 1'b1;
				end
			end
			default: begin
				start_debounce(e, active, stamp);
				o.recheck = 1'b1;
			end
		endcase
		return o;
	endfunction

	function void note_event(logic [3:0] ifc, logic pin, logic level, logic [31:0] stamp);
		expected_outcomes.push_back(predict_outcome(ifc, pin, level, stamp));
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	function void check_outcome(logic [15:0] word);
		hotplug_outcome_t want;
		if (expected_outcomes.size() == 0) begin
			$error("result word %h arrived with nothing pending", word);
			failures++;
			return;
		end
		want = expected_outcomes.pop_front();
		compare_field("out_iface", want.iface, word[3:0]);
		compare_field("power_action", want.power, word[5:4]);
		compare_field("hotplug_event", want.hotplug, word[7:6]);
		compare_field("recheck_request", want.recheck, word[8]);
		compare_field("padding", 0, word[15:9]);
	endfunction

	function int pending();
		return expected_outcomes.size();
	endfunction
endclass

module tb_top;

	// The watchdog ends the run after this many cycles without any accepted word.
	localparam int IdleLimit  = 4000;
	// Length of the one long receiver hold-off that backs the pipeline up.
	localparam int HoldCycles = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // [3:0] iface_index, [4] pin_level, [36:5] now_us, rest 0
	logic        s_tuser;  // [0] pin_select
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // [3:0] out_iface, [5:4] power_action,
	                       // [7:6] hotplug_event, [8] recheck_request, rest 0
	logic        cfg_we;
	logic [wdhp_pkg::CfgIdxW-1:0]  cfg_index;
	logic [wdhp_pkg::CfgDataW-1:0] cfg_wdata;

	hotplug_scoreboard board;

	// Stimulus state: the microsecond clock that sequences follow, the last level
	// sent on each pin, and the debounce setting that sequence timing aims at.
	logic [31:0] clock_us;
	logic [31:0] debounce_set;
	bit          last_level [32];
	int          words_sent;
	bit          quiet_tx;
	bit          hold_req;
	int          idle_cycles;

	wake_detect_debounce_hotplug_unit #(
		.NUM_IFACES(wdhp_pkg::NumIfacesDef)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one pin word. The task is entered and left at a falling edge with the
	// valid still high, so a word that follows without a gap keeps valid asserted.
	task automatic send_event(input logic [3:0] ifc, input logic pin, input logic level,
			input logic [31:0] stamp);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (quiet_tx || r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, stamp, level, ifc};
		s_tuser <= pin;
		do @(posedge clk); while (!s_tready);
		board.note_event(ifc, pin, level, stamp);
		last_level[{ifc, pin}] = level;
		words_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected result word has come back, then lets the pipeline
	// settle. Entered and left at a falling edge.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [wdhp_pkg::CfgIdxW-1:0] idx,
			input logic [wdhp_pkg::CfgDataW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		board.set_register(idx, value);
		@(negedge clk);
	endtask

	// Writes all four registers back to back. The mask registers get junk in the
	// unused upper bits of the write data, which the block must drop.
	task automatic program_config(input logic [19:0] deb, input logic [15:0] det,
			input logic [15:0] wake, input logic [15:0] ports);
		write_reg(wdhp_pkg::CfgDebounce, deb);
		write_reg(wdhp_pkg::CfgDetectPol, {4'($urandom_range(0, 15)), det});
		write_reg(wdhp_pkg::CfgWakePol, {4'($urandom_range(0, 15)), wake});
		write_reg(wdhp_pkg::CfgModulePort, {4'($urandom_range(0, 15)), ports});
		cfg_we <= 1'b0;
		debounce_set = 32'(deb);
	endtask

	// Mostly debounce sequences on one pin: a first sample, then one to three
	// rechecks whose offsets land below, on and beyond the debounce window, with an
	// occasional glitch. The rest is noise words with arbitrary timestamps.
	task automatic random_phase(input int n_words);
		int target;
		int reps;
		logic [3:0] ifc;
		logic pin;
		logic level;
		logic [31:0] start;
		logic [31:0] offset;
		target = words_sent + n_words;
		while (words_sent < target) begin
			quiet_tx = ($urandom_range(0, 6) == 0);
			if ($urandom_range(0, 4) == 0) begin
				send_event(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom), $urandom());
			end else begin
				ifc = 4'($urandom_range(0, 15));
				pin = 1'($urandom);
				// Flipping the level is what moves a settled pin, so favor it.
				level = ($urandom_range(0, 3) == 0) ? last_level[{ifc, pin}]
					: !last_level[{ifc, pin}];
				start = clock_us;
				send_event(ifc, pin, level, start);
				reps = $urandom_range(1, 3);
				repeat (reps) begin
					if ($urandom_range(0, 9) == 0)
						level = !level;
					case ($urandom_range(0, 7))
						0: offset = 0;
						1: offset = debounce_set - 1;
						2: offset = debounce_set;
						3: offset = debounce_set + $urandom_range(1, 1000);
						4: offset = $urandom_range(0, debounce_set);
						5: offset = 2 * debounce_set + $urandom_range(0, 100);
						6: offset = $urandom();
						default: offset = $urandom_range(1, 50);
					endcase
					send_event(ifc, pin, level, start + offset);
				end
				clock_us = start + 3 * debounce_set + $urandom_range(1, 5000);
			end
		end
	endtask

	// Receiver: random stalls, mostly short, sometimes long, with quiet stretches.
	// A hold request from the stimulus turns into one long hold-off counted here.
	initial begin
		int stall_left;
		int r;
		bit quiet_rx;
		stall_left = 0;
		quiet_rx = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HoldCycles;
			end else if (stall_left == 0) begin
				if ($urandom_range(0, 299) == 0)
					quiet_rx = !quiet_rx;
				r = $urandom_range(0, 99);
				if (quiet_rx || r < 70)
					stall_left = 0;
				else if (r < 90)
					stall_left = $urandom_range(1, 3);
				else if (r < 98)
					stall_left = $urandom_range(4, 12);
				else
					stall_left = $urandom_range(20, 60);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every result word taken is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_outcome(m_tdata);
	end

	// Watchdog on forward progress of either stream.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		board = new();
		idle_cycles = 0;
		words_sent = 0;
		quiet_tx = 1'b0;
		hold_req = 1'b0;
		clock_us = 32'd1000;
		debounce_set = 32'(wdhp_pkg::DebounceRst);
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wdhp_pkg::CfgDebounce;
		cfg_wdata = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset settings: 30 ms debounce, every pin active low.
		// A detect pin runs through first sample, one short of the window, exactly on
		// it, settled with no change, a glitch, a power cycle, power off and power on again.
		send_event(4'd0, 1'b1, 1'b0, 32'd1000);
		send_event(4'd0, 1'b1, 1'b0, 32'd30999);
		send_event(4'd0, 1'b1, 1'b0, 32'd31000);
		send_event(4'd0, 1'b1, 1'b0, 32'd200000);
		send_event(4'd0, 1'b1, 1'b1, 32'd200010);
		// Back to active before settling inactive: next settle is a power cycle.
		send_event(4'd0, 1'b1, 1'b0, 32'd200020);
		send_event(4'd0, 1'b1, 1'b0, 32'd230020);
		send_event(4'd0, 1'b1, 1'b1, 32'd300000);
		send_event(4'd0, 1'b1, 1'b1, 32'd330000);
		send_event(4'd0, 1'b1, 1'b0, 32'd340000);
		send_event(4'd0, 1'b1, 1'b0, 32'd370000);
		// A wake pin on an ordinary interface settles without any action.
		send_event(4'd1, 1'b0, 1'b1, 32'd400000);
		send_event(4'd1, 1'b0, 1'b1, 32'd430000);
		// Debounce window spanning the wrap of the microsecond counter.
		send_event(4'd15, 1'b1, 1'b1, 32'hFFFF_F000);
		send_event(4'd15, 1'b1, 1'b1, 32'h0000_6000);
		send_event(4'd15, 1'b1, 1'b1, 32'h0000_6530);
		send_event(4'd14, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send_event(4'd14, 1'b0, 1'b0, 32'hFFFF_FFFF);
		drain();

		// Interface 14 becomes a module port, so its wake pin now drives power and
		// hotplug; the detect pin of interface 2 becomes active high.
		program_config(20'd30000, 16'h0004, 16'h0000, 16'h4000);
		send_event(4'd14, 1'b0, 1'b0, 32'h0000_752F);
		send_event(4'd14, 1'b0, 1'b1, 32'd600000);
		send_event(4'd14, 1'b0, 1'b1, 32'd630000);
		send_event(4'd2, 1'b1, 1'b1, 32'd500000);
		send_event(4'd2, 1'b1, 1'b1, 32'd530000);
		drain();

		// Zero debounce. The receiver holds off for a long stretch while words keep
		// coming without gaps, so the block has to stall its input.
		clock_us = $urandom();
		program_config(20'd0, 16'($urandom), 16'($urandom), 16'($urandom));
		hold_req = 1'b1;
		quiet_tx = 1'b1;
		repeat (30) begin
			send_event(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom), clock_us);
			clock_us = clock_us + 32'd1;
		end
		random_phase(140);
		drain();

		program_config(20'd1000000, 16'h0000, 16'h0000, 16'h0000);
		random_phase(140);
		drain();

		clock_us = 32'hFFF0_0000;
		program_config(20'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_phase(140);
		drain();

		program_config(20'd100, 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(140);
		drain();

		program_config(20'($urandom_range(0, 1000000)), 16'($urandom), 16'($urandom),
			16'($urandom));
		random_phase(140);
		drain();

		if (board.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== wake_detect_debounce_hotplug_unit.f =====
rtl/wdhp_pkg.sv
rtl/wdhp_state_mem.sv
rtl/wdhp_step.sv
rtl/wake_detect_debounce_hotplug_unit.sv
tb/tb_top.sv
